// ===== hdl/x86_16_mov_add_decoder_unit_defines.svh =====
// ----------------------------------------------------------------------------
// x86 MOV/ADD decoder assertion macros
// Shared property wrappers for the checker of the decoder unit.
// ----------------------------------------------------------------------------
`ifndef X86_16_MOV_ADD_DECODER_UNIT_DEFINES_SVH
`define X86_16_MOV_ADD_DECODER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define X86D_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define X86D_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/x86d_pkg.sv =====
// ----------------------------------------------------------------------------
// x86 MOV/ADD decoder package
// Opcode patterns, result codes, the decoded result type and helper functions.
// ----------------------------------------------------------------------------
package x86d_pkg;

    localparam logic [3:0] OPC_MOV_IMM_HI4 = 4'b1011;
    localparam logic [5:0] OPC_MOV_RM_HI6  = 6'b100010;
    localparam logic [5:0] OPC_ADD_RM_HI6  = 6'b000000;
    localparam logic [5:0] OPC_IMM_GRP_HI6 = 6'b100000;
    localparam logic [1:0] MOD_REGISTER    = 2'b11;
    localparam logic [1:0] MOD_DISP8       = 2'b01;
    localparam logic [1:0] MOD_DISP16      = 2'b10;
    localparam logic [1:0] MOD_MEMORY      = 2'b00;
    localparam logic [2:0] RM_DIRECT       = 3'b110;

    localparam logic [2:0] FORM_MOV_RM  = 3'd0;
    localparam logic [2:0] FORM_MOV_IMM = 3'd1;
    localparam logic [2:0] FORM_ADD_RM  = 3'd2;
    localparam logic [2:0] FORM_IMM_GRP = 3'd3;
    localparam logic [2:0] FORM_INVALID = 3'd4;

    localparam logic [1:0] LEN_NONE = 2'd0;
    localparam logic [1:0] LEN_BYTE = 2'd1;
    localparam logic [1:0] LEN_WORD = 2'd2;

    typedef struct packed {
        logic [2:0]         form;
        logic               reg_is_dest;
        logic               wide;
        logic               sign_extend;
        logic [1:0]         mode_bits;
        logic [2:0]         reg_bits;
        logic [2:0]         rm_bits;
        logic signed [15:0] displacement;
        logic signed [15:0] immediate;
        logic [2:0]         length;
    } t_result;

    function automatic logic [2:0] form_of(input logic [7:0] op);
        logic [2:0] f;
        if (op[7:4] == OPC_MOV_IMM_HI4) begin
            f = FORM_MOV_IMM;
        end else if (op[7:2] == OPC_MOV_RM_HI6) begin
            f = FORM_MOV_RM;
        end else if (op[7:2] == OPC_ADD_RM_HI6) begin
            f = FORM_ADD_RM;
        end else if (op[7:2] == OPC_IMM_GRP_HI6) begin
            f = FORM_IMM_GRP;
        end else begin
            f = FORM_INVALID;
        end
        return f;
    endfunction

    function automatic logic [1:0] disp_len(input logic [7:0] modrm);
        logic [1:0] n;
        case (modrm[7:6])
            MOD_DISP8:  n = LEN_BYTE;
            MOD_DISP16: n = LEN_WORD;
            MOD_MEMORY: n = (modrm[2:0] == RM_DIRECT) ? LEN_WORD : LEN_NONE;
            default:    n = LEN_NONE;
        endcase
        return n;
    endfunction

    function automatic logic [1:0] imm_len(input logic [7:0] op);
        logic [2:0] f;
        logic [1:0] n;
        f = form_of(op);
        if (f == FORM_MOV_IMM) begin
            n = op[3] ? LEN_WORD : LEN_BYTE;
        end else if (f == FORM_IMM_GRP) begin
            n = (!op[1] && op[0]) ? LEN_WORD : LEN_BYTE;
        end else begin
            n = LEN_NONE;
        end
        return n;
    endfunction

    function automatic logic [15:0] sext8(input logic [7:0] b);
        return {{8{b[7]}}, b};
    endfunction

endpackage

// ===== hdl/x86d_collect.sv =====
// ----------------------------------------------------------------------------
// x86 MOV/ADD decoder byte collector
// Walks the instruction bytes, holds the opcode, mod/reg/rm, displacement and
// immediate, and forms the decoded result on the last byte or an unknown opcode.
// ----------------------------------------------------------------------------
module x86d_collect (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_code_byte,
    output logic              o_emit,
    output x86d_pkg::t_result o_result
);
    import x86d_pkg::*;

    typedef enum logic [2:0] {
        PH_OPCODE,
        PH_MODRM,
        PH_DISP_LO,
        PH_DISP_HI,
        PH_IMM_LO,
        PH_IMM_HI
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_opcode, n_opcode;
    logic [7:0]  r_modrm, n_modrm;
    logic [15:0] r_disp, n_disp;
    logic [15:0] r_imm, n_imm;
    logic [2:0]  r_tally, n_tally;
    logic [2:0]  tally_inc;
    logic [2:0]  len_now;
    logic [2:0]  form_in;
    logic [2:0]  form_held;
    logic        emit_ok;
    logic        emit_bad;

    assign tally_inc = r_tally + 3'd1;
    assign form_in   = form_of(i_code_byte);

    always_comb begin
        n_phase  = r_phase;
        n_opcode = r_opcode;
        n_modrm  = r_modrm;
        n_disp   = r_disp;
        n_imm    = r_imm;
        n_tally  = tally_inc;
        emit_ok  = 1'b0;
        emit_bad = 1'b0;
        unique case (r_phase)
            PH_MODRM: begin
                n_modrm = i_code_byte;
                if (disp_len(i_code_byte) != LEN_NONE) begin
                    n_phase = PH_DISP_LO;
                end else if (imm_len(r_opcode) != LEN_NONE) begin
                    n_phase = PH_IMM_LO;
                end else begin
                    emit_ok = 1'b1;
                end
            end
            PH_DISP_LO: begin
                if (disp_len(r_modrm) == LEN_WORD) begin
                    n_disp  = {8'h00, i_code_byte};
                    n_phase = PH_DISP_HI;
                end else begin
                    n_disp = sext8(i_code_byte);
                    if (imm_len(r_opcode) != LEN_NONE) begin
                        n_phase = PH_IMM_LO;
                    end else begin
                        emit_ok = 1'b1;
                    end
                end
            end
            PH_DISP_HI: begin
                n_disp = {i_code_byte, r_disp[7:0]};
                if (imm_len(r_opcode) != LEN_NONE) begin
                    n_phase = PH_IMM_LO;
                end else begin
                    emit_ok = 1'b1;
                end
            end
            PH_IMM_LO: begin
                if (imm_len(r_opcode) == LEN_WORD) begin
                    n_imm   = {8'h00, i_code_byte};
                    n_phase = PH_IMM_HI;
                end else begin
                    n_imm   = sext8(i_code_byte);
                    emit_ok = 1'b1;
                end
            end
            PH_IMM_HI: begin
                n_imm   = {i_code_byte, r_imm[7:0]};
                emit_ok = 1'b1;
            end
            default: begin
                n_modrm = 8'h00;
                n_disp  = 16'h0000;
                n_imm   = 16'h0000;
                if (form_in == FORM_INVALID) begin
                    n_opcode = 8'h00;
                    n_tally  = 3'd0;
                    n_phase  = PH_OPCODE;
                    emit_bad = 1'b1;
                end else begin
                    n_opcode = i_code_byte;
                    n_tally  = 3'd1;
                    n_phase  = (form_in == FORM_MOV_IMM) ? PH_IMM_LO : PH_MODRM;
                end
            end
        endcase
        len_now = n_tally;
        if (emit_ok) begin
            n_phase = PH_OPCODE;
            n_tally = 3'd0;
        end
    end

    assign form_held = form_of(n_opcode);

    always_comb begin
        o_result = '0;
        if (emit_bad) begin
            o_result.form   = FORM_INVALID;
            o_result.length = 3'd1;
        end else begin
            o_result.form = form_held;
            if (form_held == FORM_MOV_IMM) begin
                o_result.reg_is_dest = 1'b1;
                o_result.wide        = n_opcode[3];
                o_result.sign_extend = 1'b0;
                o_result.mode_bits   = MOD_REGISTER;
                o_result.reg_bits    = n_opcode[2:0];
                o_result.rm_bits     = 3'd0;
            end else begin
                o_result.reg_is_dest = (form_held == FORM_IMM_GRP) ? 1'b0 : n_opcode[1];
                o_result.wide        = n_opcode[0];
                o_result.sign_extend = (form_held == FORM_IMM_GRP) &&
                                       n_opcode[1] && n_opcode[0];
                o_result.mode_bits   = n_modrm[7:6];
                o_result.reg_bits    = n_modrm[5:3];
                o_result.rm_bits     = n_modrm[2:0];
            end
            o_result.displacement = n_disp;
            o_result.immediate    = n_imm;
            o_result.length       = len_now;
        end
    end

    assign o_emit = emit_ok || emit_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_OPCODE;
            r_opcode <= 8'h00;
            r_modrm  <= 8'h00;
            r_disp   <= 16'h0000;
            r_imm    <= 16'h0000;
            r_tally  <= 3'd0;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_opcode <= n_opcode;
            r_modrm  <= n_modrm;
            r_disp   <= n_disp;
            r_imm    <= n_imm;
            r_tally  <= n_tally;
        end
    end

endmodule

// ===== hdl/x86d_out_reg.sv =====
// ----------------------------------------------------------------------------
// x86 MOV/ADD decoder result register
// Holds one decoded result until the receiver takes it.
// ----------------------------------------------------------------------------
module x86d_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  x86d_pkg::t_result i_result,
    input  logic              i_out_ready,
    output logic              o_can_load,
    output logic              o_out_valid,
    output x86d_pkg::t_result o_result
);
    import x86d_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_can_load  = !r_valid || i_out_ready;
    assign o_out_valid = r_valid;
    assign o_result    = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

// ===== hdl/x86_16_mov_add_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// x86 16-bit MOV/ADD decoder unit
// Decodes mov r/m, mov immediate to register, add r/m and the immediate group
// from a byte-wide code stream.
//
// The input channel (i_in_valid, o_in_ready, i_code_byte) takes one code byte
// per transaction. The output channel (o_out_valid, i_out_ready and the field
// ports) gives one decoded result per complete instruction, or an invalid
// result of length one for an unknown opcode, after which the next byte is
// taken as a new opcode.
// A result appears in the cycle after the transaction that carries the last
// byte of its instruction. One byte is taken every cycle while the receiver
// does not stall. The result register is the only stage.
// When the receiver stalls, the result holds and o_in_ready stays low until
// the held result is taken. While no result is held, or the receiver is
// ready, a byte is taken in every cycle.
// Reset clears the collected fields, drops any held result and waits for an
// opcode byte.
// ----------------------------------------------------------------------------
module x86_16_mov_add_decoder_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_code_byte,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [2:0]         o_form,
    output logic               o_reg_is_dest,
    output logic               o_wide,
    output logic               o_sign_extend,
    output logic [1:0]         o_mode_bits,
    output logic [2:0]         o_reg_bits,
    output logic [2:0]         o_rm_bits,
    output logic signed [15:0] o_displacement,
    output logic signed [15:0] o_immediate,
    output logic [2:0]         o_length
);
    import x86d_pkg::*;

    logic    accept;
    logic    emit;
    logic    can_load;
    t_result result_next;
    t_result result_held;

    assign accept     = i_in_valid && can_load;
    assign o_in_ready = can_load;

    x86d_collect u_collect (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_code_byte (i_code_byte),
        .o_emit      (emit),
        .o_result    (result_next)
    );

    x86d_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept && emit),
        .i_result    (result_next),
        .i_out_ready (i_out_ready),
        .o_can_load  (can_load),
        .o_out_valid (o_out_valid),
        .o_result    (result_held)
    );

    assign o_form         = result_held.form;
    assign o_reg_is_dest  = result_held.reg_is_dest;
    assign o_wide         = result_held.wide;
    assign o_sign_extend  = result_held.sign_extend;
    assign o_mode_bits    = result_held.mode_bits;
    assign o_reg_bits     = result_held.reg_bits;
    assign o_rm_bits      = result_held.rm_bits;
    assign o_displacement = result_held.displacement;
    assign o_immediate    = result_held.immediate;
    assign o_length       = result_held.length;

endmodule

// ===== hdl/x86d_checker.sv =====
// ----------------------------------------------------------------------------
// x86 MOV/ADD decoder port checker
// Watches the ports of the decoder unit and flags results that break its rules.
// ----------------------------------------------------------------------------
`include "x86_16_mov_add_decoder_unit_defines.svh"

module x86d_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic [2:0]         o_form,
    input logic               o_reg_is_dest,
    input logic               o_sign_extend,
    input logic [1:0]         o_mode_bits,
    input logic [2:0]         o_rm_bits,
    input logic signed [15:0] o_displacement,
    input logic signed [15:0] o_immediate,
    input logic [2:0]         o_length
);
    import x86d_pkg::*;

    `X86D_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_form) && $stable(o_length) && $stable(o_immediate),
        "A stalled result changed before it was taken.")

    `X86D_ASSERT_NOW(a_ready_when_empty, i_clk, i_rst_n, !o_out_valid, o_in_ready,
        "The unit refused a byte with no result held.")

    `X86D_ASSERT_NOW(a_length_range, i_clk, i_rst_n, o_out_valid,
        (o_length != 3'd0) && (o_length != 3'd7),
        "A result reports an impossible instruction length.")

    `X86D_ASSERT_NOW(a_invalid_clean, i_clk, i_rst_n, o_out_valid && (o_form == FORM_INVALID),
        (o_length == 3'd1) && (o_displacement == 16'sd0) && (o_immediate == 16'sd0),
        "An invalid result carries a length or data other than its fixed values.")

    `X86D_ASSERT_NOW(a_mov_imm_fields, i_clk, i_rst_n, o_out_valid && (o_form == FORM_MOV_IMM),
        o_reg_is_dest && (o_mode_bits == MOD_REGISTER) && (o_rm_bits == 3'd0) &&
        !o_sign_extend && (o_displacement == 16'sd0),
        "A mov immediate result has inconsistent operand fields.")

endmodule

bind x86_16_mov_add_decoder_unit x86d_checker u_x86d_checker (.*);
